// ===== rtl/core/sgdl_pkg.sv =====
// sgdl_pkg: fixed widths and fixed-point formats shared by the pair update core
// and its port checker. No dependencies.
package sgdl_pkg;

    localparam int POS_W    = 31;   // path position width
    localparam int ETA_W    = 48;   // step size width, unsigned Q32.16
    localparam int ETA_FRAC = 16;
    localparam int MU_FRAC  = 32;   // mu is unsigned Q1.32, clamped to one
    localparam int MU_W     = MU_FRAC + 1;

endpackage

// ===== rtl/core/sgd_layout_pair_update_top.sv =====
// sgd_layout_pair_update_top: pipelined SGD layout update for one node pair.
// Uses sgdl_pkg, sgdl_div, sgdl_mul and sgdl_isqrt.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------
//  input   | in        | i_valid / o_stall  | xa ya xb yb path_pos_a/b step_eta
//  output  | out       | o_valid / i_stall  | new_xa ya xb yb skipped saturated
//
// one word per cycle sustained while the output word is not stalled; the mu divider,
//   the root unit and the move dividers lie in series
// reset is synchronous and clears only the valid bits
// the whole pipeline holds while the output word is stalled
module sgd_layout_pair_update_top #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COORD_WIDTH     = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_xa,
    input  logic signed [COORD_WIDTH-1:0]     i_ya,
    input  logic signed [COORD_WIDTH-1:0]     i_xb,
    input  logic signed [COORD_WIDTH-1:0]     i_yb,
    input  logic [sgdl_pkg::POS_W-1:0]        i_path_pos_a,
    input  logic [sgdl_pkg::POS_W-1:0]        i_path_pos_b,
    input  logic [sgdl_pkg::ETA_W-1:0]        i_step_eta,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [COORD_WIDTH-1:0]     o_new_xa,
    output logic signed [COORD_WIDTH-1:0]     o_new_ya,
    output logic signed [COORD_WIDTH-1:0]     o_new_xb,
    output logic signed [COORD_WIDTH-1:0]     o_new_yb,
    output logic                              o_skipped,
    output logic                              o_saturated
);
    import sgdl_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = CW + 1;
    localparam int SQW   = 2 * CW + 1;
    localparam int DSW   = POS_W + COORD_FRAC_BITS;
    localparam int DFW   = (DSW > MW) ? DSW : MW;
    localparam int PRW   = DFW + CW;
    localparam int TMW   = DFW + MU_W;
    localparam int EXW   = ((CW > DFW) ? CW : DFW) + 2;
    localparam int NUM_W = ETA_W + MU_FRAC - ETA_FRAC;
    localparam int SA_W  = 6 * CW + 4 + POS_W;
    localparam int SX1_W = 3 * CW + 2 + MU_W + POS_W;
    localparam int SY1_W = 3 * CW + 1;
    localparam int SX4_W = 2 * CW + 2 + MU_W;
    localparam int SY4_W = 2 * CW + 1 + MU_W;
    localparam logic signed [EXW-1:0] C_MAX = EXW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [EXW-1:0] C_MIN = ~C_MAX;

    function automatic logic [CW:0] clamp_c(input logic signed [EXW-1:0] v);
        logic [CW:0] res;
        if (v > C_MAX) begin
            res = {1'b1, C_MAX[CW-1:0]};
        end else if (v < C_MIN) begin
            res = {1'b1, C_MIN[CW-1:0]};
        end else begin
            res = {1'b0, v[CW-1:0]};
        end
        return res;
    endfunction

    logic w_adv;
    logic r_out_valid;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    // input register
    logic                    r1_valid;
    logic signed [CW-1:0]    r1_xa, r1_ya, r1_xb, r1_yb;
    logic [POS_W-1:0]        r1_pa, r1_pb;
    logic [ETA_W-1:0]        r1_eta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_xa  <= i_xa;
            r1_ya  <= i_ya;
            r1_xb  <= i_xb;
            r1_yb  <= i_yb;
            r1_pa  <= i_path_pos_a;
            r1_pb  <= i_path_pos_b;
            r1_eta <= i_step_eta;
        end
    end

    logic [POS_W-1:0]   w_d;
    logic               w_skip;
    logic signed [CW:0] w_dx, w_dy, w_dxz, w_dyz;
    logic               w_dxneg, w_dyneg;
    logic [CW-1:0]      w_ax, w_ay;
    logic [NUM_W-1:0]   w_num;
    logic               w_mubig;
    logic [POS_W-1:0]   w_mu_hi;
    logic [SA_W-1:0]    w_sa;

    always_comb begin
        w_d     = (r1_pa > r1_pb) ? (r1_pa - r1_pb) : (r1_pb - r1_pa);
        w_skip  = (w_d == '0);
        w_dx    = (CW+1)'(r1_xa) - (CW+1)'(r1_xb);
        w_dy    = (CW+1)'(r1_ya) - (CW+1)'(r1_yb);
        // a zero difference counts as one lsb
        w_dxz   = (w_dx == '0) ? (CW+1)'(1) : w_dx;
        w_dyz   = (w_dy == '0) ? (CW+1)'(1) : w_dy;
        w_dxneg = w_dxz[CW];
        w_dyneg = w_dyz[CW];
        w_ax    = w_dxneg ? CW'(-w_dxz) : CW'(w_dxz);
        w_ay    = w_dyneg ? CW'(-w_dyz) : CW'(w_dyz);
        w_num   = {r1_eta, {(MU_FRAC-ETA_FRAC){1'b0}}};
        // quotient of at least one: mu clamps, divider result unused
        w_mubig = w_num[NUM_W-1:MU_FRAC] >= (NUM_W-MU_FRAC)'(w_d);
        w_mu_hi = w_mubig ? '0 : POS_W'(w_num[NUM_W-1:MU_FRAC]);
        w_sa    = {r1_xa, r1_ya, r1_xb, r1_yb, w_ax, w_ay, w_dxneg, w_dyneg,
                   w_skip, w_mubig, w_d};
    end

    // mu = eta / d
    logic                  w_a_valid;
    logic [MU_FRAC-1:0]    w_a_quo;
    logic [SA_W-1:0]       w_a_side;

    sgdl_div #(.QW(MU_FRAC), .DW(POS_W), .SW(SA_W)) u_mu_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (r1_valid),
        .i_num_hi (w_mu_hi),
        .i_num_lo (w_num[MU_FRAC-1:0]),
        .i_den    (w_d),
        .i_side   (w_sa),
        .o_valid  (w_a_valid),
        .o_quo    (w_a_quo),
        .o_side   (w_a_side)
    );

    logic signed [CW-1:0] a_xa, a_ya, a_xb, a_yb;
    logic [CW-1:0]        a_ax, a_ay;
    logic                 a_dxneg, a_dyneg, a_skip, a_mubig;
    logic [POS_W-1:0]     a_d;
    logic [MU_W-1:0]      w_a_mu;

    assign {a_xa, a_ya, a_xb, a_yb, a_ax, a_ay, a_dxneg, a_dyneg,
            a_skip, a_mubig, a_d} = w_a_side;
    assign w_a_mu = a_mubig ? (MU_W'(1) << MU_FRAC) : MU_W'(w_a_quo);

    // squares
    logic              w_b_vx, w_b_vy;
    logic [2*CW-1:0]   w_b_px, w_b_py;
    logic [SX1_W-1:0]  w_b_sx;
    logic [SY1_W-1:0]  w_b_sy;

    sgdl_mul #(.AW(CW), .BW(CW), .SW(SX1_W)) u_sq_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_a_valid),
        .i_a     (a_ax),
        .i_b     (a_ax),
        .i_side  ({a_xa, a_xb, a_ax, a_dxneg, a_skip, w_a_mu, a_d}),
        .o_valid (w_b_vx),
        .o_prod  (w_b_px),
        .o_side  (w_b_sx)
    );

    sgdl_mul #(.AW(CW), .BW(CW), .SW(SY1_W)) u_sq_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_a_valid),
        .i_a     (a_ay),
        .i_b     (a_ay),
        .i_side  ({a_ya, a_yb, a_ay, a_dyneg}),
        .o_valid (w_b_vy),
        .o_prod  (w_b_py),
        .o_side  (w_b_sy)
    );

    logic              r3_valid;
    logic [SQW-1:0]    r3_sum;
    logic [SX1_W-1:0]  r3_sx;
    logic [SY1_W-1:0]  r3_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= w_b_vx & w_b_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_sum <= SQW'(w_b_px) + SQW'(w_b_py);
            r3_sx  <= w_b_sx;
            r3_sy  <= w_b_sy;
        end
    end

    // mag = floor(sqrt(dx^2 + dy^2))
    logic                     w_c_valid;
    logic [MW-1:0]            w_c_root;
    logic [SX1_W+SY1_W-1:0]   w_c_side;

    sgdl_isqrt #(.NW(SQW), .RW(MW), .SW(SX1_W + SY1_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r3_valid),
        .i_rad   (r3_sum),
        .i_side  ({r3_sx, r3_sy}),
        .o_valid (w_c_valid),
        .o_root  (w_c_root),
        .o_side  (w_c_side)
    );

    logic signed [CW-1:0] c_xa, c_xb, c_ya, c_yb;
    logic [CW-1:0]        c_ax, c_ay;
    logic                 c_dxneg, c_dyneg, c_skip;
    logic [MU_W-1:0]      c_mu;
    logic [POS_W-1:0]     c_d;
    logic [DFW-1:0]       w_dsc, w_magx, w_diff;
    logic                 w_diff_neg;

    assign {c_xa, c_xb, c_ax, c_dxneg, c_skip, c_mu, c_d,
            c_ya, c_yb, c_ay, c_dyneg} = w_c_side;

    always_comb begin
        w_dsc      = DFW'({c_d, {COORD_FRAC_BITS{1'b0}}});
        w_magx     = DFW'(w_c_root);
        w_diff_neg = w_magx < w_dsc;
        w_diff     = w_diff_neg ? (w_dsc - w_magx) : (w_magx - w_dsc);
    end

    logic              r4_valid;
    logic [DFW-1:0]    r4_diff;
    logic [MW-1:0]     r4_mag;
    logic [CW-1:0]     r4_ax, r4_ay;
    logic [SX4_W-1:0]  r4_sx;
    logic [SY4_W-1:0]  r4_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r4_valid <= w_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_diff <= w_diff;
            r4_mag  <= w_c_root;
            r4_ax   <= c_ax;
            r4_ay   <= c_ay;
            r4_sx   <= {c_xa, c_xb, w_diff_neg ^ c_dxneg, c_skip, c_mu};
            r4_sy   <= {c_ya, c_yb, w_diff_neg ^ c_dyneg, c_mu};
        end
    end

    // |diff| * |dx|, |diff| * |dy|
    logic              w_e_vx, w_e_vy;
    logic [PRW-1:0]    w_e_px, w_e_py;
    logic [SX4_W+MW-1:0] w_e_sx;
    logic [SY4_W+MW-1:0] w_e_sy;

    sgdl_mul #(.AW(DFW), .BW(CW), .SW(SX4_W + MW)) u_dm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r4_valid),
        .i_a     (r4_diff),
        .i_b     (r4_ax),
        .i_side  ({r4_sx, r4_mag}),
        .o_valid (w_e_vx),
        .o_prod  (w_e_px),
        .o_side  (w_e_sx)
    );

    sgdl_mul #(.AW(DFW), .BW(CW), .SW(SY4_W + MW)) u_dm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r4_valid),
        .i_a     (r4_diff),
        .i_b     (r4_ay),
        .i_side  ({r4_sy, r4_mag}),
        .o_valid (w_e_vy),
        .o_prod  (w_e_py),
        .o_side  (w_e_sy)
    );

    logic [SX4_W-1:0] e_sx;
    logic [SY4_W-1:0] e_sy;
    logic [MW-1:0]    e_magx, e_magy;

    assign {e_sx, e_magx} = w_e_sx;
    assign {e_sy, e_magy} = w_e_sy;

    // divide by mag; |dx| <= mag keeps the quotient within the diff width
    logic              w_f_vx, w_f_vy;
    logic [DFW-1:0]    w_f_qx, w_f_qy;
    logic [SX4_W-1:0]  w_f_sx;
    logic [SY4_W-1:0]  w_f_sy;

    sgdl_div #(.QW(DFW), .DW(MW), .SW(SX4_W)) u_mv_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (w_e_vx),
        .i_num_hi (MW'(w_e_px[PRW-1:DFW])),
        .i_num_lo (w_e_px[DFW-1:0]),
        .i_den    (e_magx),
        .i_side   (e_sx),
        .o_valid  (w_f_vx),
        .o_quo    (w_f_qx),
        .o_side   (w_f_sx)
    );

    sgdl_div #(.QW(DFW), .DW(MW), .SW(SY4_W)) u_mv_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (w_e_vy),
        .i_num_hi (MW'(w_e_py[PRW-1:DFW])),
        .i_num_lo (w_e_py[DFW-1:0]),
        .i_den    (e_magy),
        .i_side   (e_sy),
        .o_valid  (w_f_vy),
        .o_quo    (w_f_qy),
        .o_side   (w_f_sy)
    );

    logic signed [CW-1:0] f_xa, f_xb, f_ya, f_yb;
    logic                 f_negx, f_negy, f_skip;
    logic [MU_W-1:0]      f_mux, f_muy;

    assign {f_xa, f_xb, f_negx, f_skip, f_mux} = w_f_sx;
    assign {f_ya, f_yb, f_negy, f_muy}         = w_f_sy;

    // scale by mu
    logic                 w_g_vx, w_g_vy;
    logic [TMW-1:0]       w_g_px, w_g_py;
    logic [2*CW+1:0]      w_g_sx;
    logic [2*CW:0]        w_g_sy;

    sgdl_mul #(.AW(DFW), .BW(MU_W), .SW(2 * CW + 2)) u_mu_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_f_vx),
        .i_a     (w_f_qx),
        .i_b     (f_mux),
        .i_side  ({f_xa, f_xb, f_negx, f_skip}),
        .o_valid (w_g_vx),
        .o_prod  (w_g_px),
        .o_side  (w_g_sx)
    );

    sgdl_mul #(.AW(DFW), .BW(MU_W), .SW(2 * CW + 1)) u_mu_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_f_vy),
        .i_a     (w_f_qy),
        .i_b     (f_muy),
        .i_side  ({f_ya, f_yb, f_negy}),
        .o_valid (w_g_vy),
        .o_prod  (w_g_py),
        .o_side  (w_g_sy)
    );

    logic signed [CW-1:0]  g_xa, g_xb, g_ya, g_yb;
    logic                  g_negx, g_negy, g_skip;
    logic signed [EXW-1:0] w_mvx, w_mvy;
    logic [CW:0]           w_cxa, w_cxb, w_cya, w_cyb;

    assign {g_xa, g_xb, g_negx, g_skip} = w_g_sx;
    assign {g_ya, g_yb, g_negy}         = w_g_sy;

    always_comb begin
        // move = (t * mu) >> (MU_FRAC + 1), sign applied after
        w_mvx = EXW'(w_g_px[TMW-1:MU_FRAC+1]);
        w_mvy = EXW'(w_g_py[TMW-1:MU_FRAC+1]);
        if (g_negx) begin
            w_mvx = -w_mvx;
        end
        if (g_negy) begin
            w_mvy = -w_mvy;
        end
        w_cxa = clamp_c(EXW'(g_xa) - w_mvx);
        w_cya = clamp_c(EXW'(g_ya) - w_mvy);
        w_cxb = clamp_c(EXW'(g_xb) + w_mvx);
        w_cyb = clamp_c(EXW'(g_yb) + w_mvy);
    end

    // output register
    logic signed [CW-1:0] r_new_xa, r_new_ya, r_new_xb, r_new_yb;
    logic                 r_skipped, r_saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_g_vx & w_g_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (g_skip) begin
                r_new_xa    <= g_xa;
                r_new_ya    <= g_ya;
                r_new_xb    <= g_xb;
                r_new_yb    <= g_yb;
                r_skipped   <= 1'b1;
                r_saturated <= 1'b0;
            end else begin
                r_new_xa    <= w_cxa[CW-1:0];
                r_new_ya    <= w_cya[CW-1:0];
                r_new_xb    <= w_cxb[CW-1:0];
                r_new_yb    <= w_cyb[CW-1:0];
                r_skipped   <= 1'b0;
                r_saturated <= w_cxa[CW] | w_cya[CW] | w_cxb[CW] | w_cyb[CW];
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_new_xa    = r_new_xa;
    assign o_new_ya    = r_new_ya;
    assign o_new_xb    = r_new_xb;
    assign o_new_yb    = r_new_yb;
    assign o_skipped   = r_skipped;
    assign o_saturated = r_saturated;

endmodule

// ===== rtl/core/sgdl_mul.sv =====
// sgdl_mul: two-stage unsigned multiplier built from four half-width partial
// products, with a valid bit and a side word carried alongside. No dependencies.
module sgdl_mul #(
    parameter int AW = 40,
    parameter int BW = 40,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [AW+BW-1:0]     o_prod,
    output logic [SW-1:0]        o_side
);
    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [1:0]         r_valid;
    logic [AL+BL-1:0]   r_ll;
    logic [AL+BH-1:0]   r_lh;
    logic [AH+BL-1:0]   r_hl;
    logic [AH+BH-1:0]   r_hh;
    logic [SW-1:0]      r_side1;
    logic [PW-1:0]      r_prod;
    logic [SW-1:0]      r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh    <= i_a[AL-1:0] * i_b[BW-1:BL];
            r_hl    <= i_a[AW-1:AL] * i_b[BL-1:0];
            r_hh    <= i_a[AW-1:AL] * i_b[BW-1:BL];
            r_side1 <= i_side;
            r_prod  <= PW'(r_ll) + (PW'(r_lh) << BL) + (PW'(r_hl) << AL)
                     + (PW'(r_hh) << (AL + BL));
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_valid[1];
    assign o_prod  = r_prod;
    assign o_side  = r_side2;

endmodule

// ===== rtl/core/sgdl_div.sv =====
// sgdl_div: pipelined restoring divider, one quotient bit per stage. The upper
// numerator part must be below the divisor. No dependencies.
module sgdl_div #(
    parameter int QW = 32,
    parameter int DW = 31,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num_hi,
    input  logic [QW-1:0] i_num_lo,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    logic [QW:0]   r_valid;
    logic [DW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_nq   [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [SW-1:0] r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num_hi;
            r_nq[0]   <= i_num_lo;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] w_part;
        logic        w_take;

        // shift in the next numerator bit, subtract when it fits
        assign w_part = {r_rem[k], r_nq[k][QW-1]};
        assign w_take = w_part >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_take ? DW'(w_part - {1'b0, r_den[k]}) : w_part[DW-1:0];
                r_nq[k+1]   <= {r_nq[k][QW-2:0], w_take};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[QW];
    assign o_quo   = r_nq[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== rtl/core/sgdl_isqrt.sv =====
// sgdl_isqrt: pipelined integer square root (floor), one root bit per stage,
// remainder kept as radicand minus root squared. No dependencies.
module sgdl_isqrt #(
    parameter int NW = 81,
    parameter int RW = 41,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rad,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);
    localparam int TW = 2 * RW + 1;

    logic [RW:0]   r_valid;
    logic [NW-1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic [SW-1:0] r_side [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[RW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rad;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int B = RW - 1 - k;
        logic [TW-1:0] w_remx;
        logic [TW-1:0] w_trial;
        logic          w_take;

        // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
        assign w_remx  = TW'(r_rem[k]);
        assign w_trial = (TW'(r_root[k]) << (B + 1)) | (TW'(1) << (2 * B));
        assign w_take  = w_remx >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_take ? NW'(w_remx - w_trial) : r_rem[k];
                r_root[k+1] <= w_take ? (r_root[k] | (RW'(1) << B)) : r_root[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

// ===== rtl/core/sgdl_checker.sv =====
// sgdl_checker: port-level checks for sgd_layout_pair_update_top, bound to it
// below. Uses sgdl_pkg for the fixed port widths.
module sgdl_checker #(
    parameter int COORD_WIDTH = 40
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic signed [COORD_WIDTH-1:0]     i_xa,
    input logic signed [COORD_WIDTH-1:0]     i_ya,
    input logic signed [COORD_WIDTH-1:0]     i_xb,
    input logic signed [COORD_WIDTH-1:0]     i_yb,
    input logic [sgdl_pkg::POS_W-1:0]        i_path_pos_a,
    input logic [sgdl_pkg::POS_W-1:0]        i_path_pos_b,
    input logic [sgdl_pkg::ETA_W-1:0]        i_step_eta,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [COORD_WIDTH-1:0]     o_new_xa,
    input logic signed [COORD_WIDTH-1:0]     o_new_ya,
    input logic signed [COORD_WIDTH-1:0]     o_new_xb,
    input logic signed [COORD_WIDTH-1:0]     o_new_yb,
    input logic                              o_skipped,
    input logic                              o_saturated
);
    import sgdl_pkg::*;

    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = ~C_MAX;

    // input side only backs up behind a stalled output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output word");

    a_skip_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_skipped) |-> !o_saturated)
        else $error("skipped pair flagged as saturated");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_new_xa == C_MAX || o_new_xa == C_MIN || o_new_ya == C_MAX ||
             o_new_ya == C_MIN || o_new_xb == C_MAX || o_new_xb == C_MIN ||
             o_new_yb == C_MAX || o_new_yb == C_MIN))
        else $error("saturated flag with no coordinate on a rail");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_new_xa) && $stable(o_new_ya)
            && $stable(o_new_xb) && $stable(o_new_yb)
            && $stable(o_skipped) && $stable(o_saturated)))
        else $error("stalled output word changed");

    // a stalled input word is held by the sender
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_xa) && $stable(i_ya)
            && $stable(i_xb) && $stable(i_yb) && $stable(i_path_pos_a)
            && $stable(i_path_pos_b) && $stable(i_step_eta)))
        else $error("stalled input word changed");

endmodule

bind sgd_layout_pair_update_top sgdl_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sgdl_checker (.*);
